// ===== design/grid_cell_tetrahedra_indexer_top_macros.svh =====
// Assertion macros for the grid cell tetrahedra indexer
`ifndef GRID_CELL_TETRAHEDRA_INDEXER_TOP_MACROS_SVH
`define GRID_CELL_TETRAHEDRA_INDEXER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GCTI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gcti assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GCTI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gcti assertion failed");

`endif

// ===== design/gcti_pkg.sv =====
// Shared types, constants and the tetrahedron table of the grid cell indexer
`default_nettype none
package gcti_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int MIN_POINTS     = 2;
	localparam int CFG_RAW_W      = 9;
	localparam int APB_DW         = 32;
	localparam int APB_AW         = 4;
	localparam int COORD_W        = 8;
	localparam int IDX_W          = 24;
	localparam int SLOT_W         = 3;
	localparam int BORDER_W       = 6;
	localparam int VERT_W         = 3;
	localparam int NUM_TETS       = 5;

	localparam logic [SLOT_W-1:0] SLOT_FIRST = '0;
	localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(NUM_TETS - 1);

	// border mask bit positions
	localparam int BRD_LEFT   = 0;
	localparam int BRD_RIGHT  = 1;
	localparam int BRD_BOTTOM = 2;
	localparam int BRD_TOP    = 3;
	localparam int BRD_BACK   = 4;
	localparam int BRD_FRONT  = 5;

	typedef enum logic [1:0] {
		REG_POINTS_X = 2'd0,
		REG_POINTS_Y = 2'd1,
		REG_POINTS_Z = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_z;
	} cell_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]    cell_index;
		logic [SLOT_W-1:0]   tet_slot;
		logic [IDX_W-1:0]    corner_a;
		logic [IDX_W-1:0]    corner_b;
		logic [IDX_W-1:0]    corner_c;
		logic [IDX_W-1:0]    corner_d;
		logic [BORDER_W-1:0] cell_border;
		logic                flip;
		logic                error;
		logic                last;
	} tet_out_t;

	// One resolved cell: even corners of the cell, odd ones are these plus one.
	typedef struct packed {
		logic                err;
		logic [IDX_W-1:0]    cell_index;
		logic [IDX_W-1:0]    b0;
		logic [IDX_W-1:0]    b2;
		logic [IDX_W-1:0]    b4;
		logic [IDX_W-1:0]    b6;
		logic [BORDER_W-1:0] border;
		logic                flip;
	} cell_t;

	// Corner numbers {a,b,c,d} of one tetrahedron of the split.
	function automatic logic [4*VERT_W-1:0] tet_verts(input logic flip,
			input logic [SLOT_W-1:0] slot);
		logic [SLOT_W:0] key;
		logic [4*VERT_W-1:0] v;
		key = {flip, slot};
		case (key)
			4'b0_000: v = {3'd0, 3'd1, 3'd2, 3'd4};
			4'b0_001: v = {3'd1, 3'd3, 3'd2, 3'd7};
			4'b0_010: v = {3'd2, 3'd6, 3'd4, 3'd7};
			4'b0_011: v = {3'd4, 3'd5, 3'd7, 3'd1};
			4'b0_100: v = {3'd2, 3'd4, 3'd1, 3'd7};
			4'b1_000: v = {3'd0, 3'd1, 3'd3, 3'd5};
			4'b1_001: v = {3'd2, 3'd0, 3'd3, 3'd6};
			4'b1_010: v = {3'd7, 3'd4, 3'd3, 3'd6};
			4'b1_011: v = {3'd4, 3'd5, 3'd6, 3'd0};
			4'b1_100: v = {3'd0, 3'd3, 3'd6, 3'd5};
			default:  v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== design/gcti_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per transaction
`default_nettype none
interface gcti_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/gcti_cfg_regs.sv =====
// APB register block holding the grid point counts per axis
`default_nettype none
module gcti_cfg_regs import gcti_pkg::*; #(
	parameter int MAX_POINTS_PER_AXIS = MAX_POINTS_DEF,
	localparam int PW = $clog2(MAX_POINTS_PER_AXIS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output logic      [PW-1:0]     points_x,
	output logic      [PW-1:0]     points_y,
	output logic      [PW-1:0]     points_z
);

	localparam int unsigned MAXP = MAX_POINTS_PER_AXIS;
	localparam int unsigned MINP = MIN_POINTS;

	logic [PW-1:0] px_q, py_q, pz_q;
	logic [PW-1:0] wr_val;
	logic          wr_en;
	reg_idx_t      wr_idx;

	function automatic logic [PW-1:0] clamp_pts(input logic [CFG_RAW_W-1:0] v);
		logic [PW-1:0] r;
		if (32'(v) < MINP) begin
			r = PW'(MINP);
		end else if (32'(v) > MAXP) begin
			r = PW'(MAXP);
		end else begin
			r = PW'(v);
		end
		return r;
	endfunction

	assign wr_en  = psel && penable && pwrite;
	assign wr_idx = reg_idx_t'(paddr[3:2]);
	assign wr_val = clamp_pts(pwdata[CFG_RAW_W-1:0]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= PW'(MINP);
			py_q <= PW'(MINP);
			pz_q <= PW'(MINP);
		end else if (wr_en) begin
			case (wr_idx)
				REG_POINTS_X: px_q <= wr_val;
				REG_POINTS_Y: py_q <= wr_val;
				REG_POINTS_Z: pz_q <= wr_val;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_POINTS_X: prdata = APB_DW'(px_q);
			REG_POINTS_Y: prdata = APB_DW'(py_q);
			REG_POINTS_Z: prdata = APB_DW'(pz_q);
			default:      prdata = '0;
		endcase
	end

	assign points_x = px_q;
	assign points_y = py_q;
	assign points_z = pz_q;

endmodule
`default_nettype wire

// ===== design/gcti_addr_pipe.sv =====
// Three-stage pipeline resolving a cell coordinate to corner and cell indices
`default_nettype none
module gcti_addr_pipe import gcti_pkg::*; #(
	parameter int MAX_POINTS_PER_AXIS = MAX_POINTS_DEF,
	localparam int PW = $clog2(MAX_POINTS_PER_AXIS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [PW-1:0] points_x,
	input  wire logic [PW-1:0] points_y,
	input  wire logic [PW-1:0] points_z,
	gcti_stream_if.sink        cell_in,
	output cell_t              cell_o,
	output logic               cell_v,
	input  wire logic          cell_rdy
);

	localparam int CW = (PW > COORD_W) ? PW : COORD_W;

	// stage 1: bounds, border, flip, products of y and of the config
	logic               v_s1, err_s1, flip_s1;
	logic [COORD_W-1:0] x_s1, z_s1;
	logic [BORDER_W-1:0] border_s1;
	logic [IDX_W-1:0]   yrow_s1, ycol_s1, row_s1, slice_s1, cslice_s1;
	// stage 2: products of z, partial sums
	logic               v_s2, err_s2, flip_s2;
	logic [BORDER_W-1:0] border_s2;
	logic [IDX_W-1:0]   zs_s2, zs1_s2, zc_s2, yr0_s2, yr2_s2, cip_s2;
	// stage 3: resolved cell
	logic               v_s3;
	cell_t              cell_s3;

	logic rdy1, rdy2, rdy3;
	logic [PW-1:0] nx1, ny1, nz1;
	logic [CW:0]   xe, ye, ze, nx1e, ny1e, nz1e;
	logic          err_c;
	logic [BORDER_W-1:0] border_c;

	assign rdy3 = !v_s3 || cell_rdy;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign cell_in.ready = rdy1;

	always_comb begin
		nx1  = points_x - PW'(1);
		ny1  = points_y - PW'(1);
		nz1  = points_z - PW'(1);
		xe   = (CW+1)'(cell_in.data.cell_x);
		ye   = (CW+1)'(cell_in.data.cell_y);
		ze   = (CW+1)'(cell_in.data.cell_z);
		nx1e = (CW+1)'(nx1);
		ny1e = (CW+1)'(ny1);
		nz1e = (CW+1)'(nz1);
		err_c = (xe >= nx1e) || (ye >= ny1e) || (ze >= nz1e);
		border_c = '0;
		border_c[BRD_LEFT]   = (xe == '0);
		border_c[BRD_RIGHT]  = (xe + (CW+1)'(1) == nx1e);
		border_c[BRD_BOTTOM] = (ye == '0);
		border_c[BRD_TOP]    = (ye + (CW+1)'(1) == ny1e);
		border_c[BRD_BACK]   = (ze == '0);
		border_c[BRD_FRONT]  = (ze + (CW+1)'(1) == nz1e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= cell_in.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			err_s1    <= err_c;
			flip_s1   <= err_c ? 1'b0 :
				(cell_in.data.cell_x[0] ^ cell_in.data.cell_y[0] ^ cell_in.data.cell_z[0]);
			border_s1 <= err_c ? '0 : border_c;
			x_s1      <= cell_in.data.cell_x;
			z_s1      <= cell_in.data.cell_z;
			yrow_s1   <= IDX_W'(cell_in.data.cell_y) * IDX_W'(points_x);
			ycol_s1   <= IDX_W'(cell_in.data.cell_y) * IDX_W'(nx1);
			row_s1    <= IDX_W'(points_x);
			slice_s1  <= IDX_W'(points_x) * IDX_W'(points_y);
			cslice_s1 <= IDX_W'(nx1) * IDX_W'(ny1);
		end
		if (rdy2) begin
			err_s2    <= err_s1;
			flip_s2   <= flip_s1;
			border_s2 <= border_s1;
			zs_s2     <= IDX_W'(z_s1) * slice_s1;
			zs1_s2    <= (IDX_W'(z_s1) + IDX_W'(1)) * slice_s1;
			zc_s2     <= IDX_W'(z_s1) * cslice_s1;
			yr0_s2    <= yrow_s1 + IDX_W'(x_s1);
			yr2_s2    <= yrow_s1 + row_s1 + IDX_W'(x_s1);
			cip_s2    <= ycol_s1 + IDX_W'(x_s1);
		end
		if (rdy3) begin
			cell_s3.err    <= err_s2;
			cell_s3.border <= border_s2;
			cell_s3.flip   <= flip_s2;
			if (err_s2) begin
				cell_s3.cell_index <= '0;
				cell_s3.b0 <= '0;
				cell_s3.b2 <= '0;
				cell_s3.b4 <= '0;
				cell_s3.b6 <= '0;
			end else begin
				cell_s3.cell_index <= zc_s2 + cip_s2;
				cell_s3.b0 <= zs_s2 + yr0_s2;
				cell_s3.b2 <= zs_s2 + yr2_s2;
				cell_s3.b4 <= zs1_s2 + yr0_s2;
				cell_s3.b6 <= zs1_s2 + yr2_s2;
			end
		end
	end

	assign cell_o = cell_s3;
	assign cell_v = v_s3;

endmodule
`default_nettype wire

// ===== design/gcti_tet_emit.sv =====
// Cell holding register and output register issuing a cell's five tetrahedra, or one error result
`default_nettype none
module gcti_tet_emit import gcti_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cell_t cell_i,
	input  wire logic  cell_v,
	output logic       cell_rdy,
	gcti_stream_if.source tet_out
);

	cell_t             cell_q;
	logic              hold_q;
	logic [SLOT_W-1:0] slot_q;
	logic              out_v_q;
	tet_out_t          out_q;

	logic              load, emit, last_now;
	logic [4*VERT_W-1:0] verts;
	tet_out_t          nxt;

	function automatic logic [IDX_W-1:0] corner_of(input cell_t c,
			input logic [VERT_W-1:0] s);
		logic [IDX_W-1:0] b;
		b = s[2] ? (s[1] ? c.b6 : c.b4) : (s[1] ? c.b2 : c.b0);
		return b + IDX_W'(s[0]);
	endfunction

	assign load     = !out_v_q || tet_out.ready;
	assign emit     = hold_q && load;
	assign last_now = cell_q.err || (slot_q == SLOT_LAST);
	assign cell_rdy = !hold_q || (emit && last_now);

	always_comb begin
		verts = tet_verts(cell_q.flip, slot_q);
		nxt   = '0;
		if (cell_q.err) begin
			nxt.error = 1'b1;
			nxt.last  = 1'b1;
		end else begin
			nxt.cell_index  = cell_q.cell_index;
			nxt.tet_slot    = slot_q;
			nxt.corner_a    = corner_of(cell_q, verts[4*VERT_W-1:3*VERT_W]);
			nxt.corner_b    = corner_of(cell_q, verts[3*VERT_W-1:2*VERT_W]);
			nxt.corner_c    = corner_of(cell_q, verts[2*VERT_W-1:VERT_W]);
			nxt.corner_d    = corner_of(cell_q, verts[VERT_W-1:0]);
			nxt.cell_border = cell_q.border;
			nxt.flip        = cell_q.flip;
			nxt.last        = (slot_q == SLOT_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= 1'b0;
			slot_q  <= SLOT_FIRST;
			out_v_q <= 1'b0;
		end else begin
			if (load) out_v_q <= hold_q;
			// take a new cell once the held one has issued its final result
			if (cell_rdy) begin
				hold_q <= cell_v;
				slot_q <= SLOT_FIRST;
			end else if (emit) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cell_rdy) cell_q <= cell_i;
		if (emit) out_q <= nxt;
	end

	assign tet_out.valid = out_v_q;
	assign tet_out.data  = out_q;

endmodule
`default_nettype wire

// ===== design/grid_cell_tetrahedra_indexer_top.sv =====
// Top level of the grid cell five-tetrahedra indexer
// Takes one grid cell (cell_x, cell_y, cell_z) per transaction and returns the five
// tetrahedra that split it, slots 0 to 4 in order, each as four global point indices
// together with the cell index, border mask and checkerboard flip; a cell outside the
// grid gives one result with error and last set and all other fields zero. A valid
// cell occupies the result channel for five transfers and an out-of-range cell for one;
// the channel moves one tetrahedron per cycle while tet_out.ready is held high, and input
// is taken back to back while earlier cells are still resolving. Each cell passes three
// address stages (bounds and y products, z products, final sums), the cell holding
// register and the output register before its first result. Point counts per axis are
// written over APB at 0x0, 0x4, 0x8 (clamped to 2..MAX_POINTS_PER_AXIS, reset 2) and
// should only be changed while no cell is in flight.
`default_nettype none
`include "grid_cell_tetrahedra_indexer_top_macros.svh"
module grid_cell_tetrahedra_indexer_top import gcti_pkg::*; #(
	parameter int MAX_POINTS_PER_AXIS = MAX_POINTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	gcti_stream_if.sink            cell_in,
	gcti_stream_if.source          tet_out
);

	localparam int PW = $clog2(MAX_POINTS_PER_AXIS + 1);
	localparam int unsigned MAXP = MAX_POINTS_PER_AXIS;

	logic [PW-1:0] points_x, points_y, points_z;
	cell_t         cell_res;
	logic          cell_v, cell_rdy;

	gcti_cfg_regs #(.MAX_POINTS_PER_AXIS(MAX_POINTS_PER_AXIS)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.points_x (points_x),
		.points_y (points_y),
		.points_z (points_z)
	);

	gcti_addr_pipe #(.MAX_POINTS_PER_AXIS(MAX_POINTS_PER_AXIS)) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.points_x (points_x),
		.points_y (points_y),
		.points_z (points_z),
		.cell_in  (cell_in),
		.cell_o   (cell_res),
		.cell_v   (cell_v),
		.cell_rdy (cell_rdy)
	);

	gcti_tet_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.cell_i   (cell_res),
		.cell_v   (cell_v),
		.cell_rdy (cell_rdy),
		.tet_out  (tet_out)
	);

	// a non-final tetrahedron is followed at once by the next slot of the same cell
	`GCTI_ASSERT_NEXT(a_slot_advance, tet_out.valid && tet_out.ready && !tet_out.data.last, tet_out.valid && tet_out.data.tet_slot == SLOT_W'($past(tet_out.data.tet_slot) + SLOT_W'(1)))
	// after the final result of a cell the next result starts at slot zero
	`GCTI_ASSERT_NEXT(a_slot_restart, tet_out.valid && tet_out.ready && tet_out.data.last, !tet_out.valid || tet_out.data.tet_slot == SLOT_FIRST)
	// point counts stay within the clamped range
	`GCTI_ASSERT_NOW(a_cfg_range, 1'b1, 32'(points_x) >= 32'(MIN_POINTS) && 32'(points_x) <= MAXP && 32'(points_y) >= 32'(MIN_POINTS) && 32'(points_y) <= MAXP && 32'(points_z) >= 32'(MIN_POINTS) && 32'(points_z) <= MAXP)

endmodule
`default_nettype wire

// ===== tb/grid_cell_tetrahedra_indexer_checker.sv =====
// Checker for the grid cell indexer: tracks the axis registers, predicts each cell's tetrahedra
module grid_cell_tetrahedra_indexer_checker import gcti_pkg::*; #(
	parameter int MAX_POINTS_PER_AXIS = MAX_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              pready,
	input  logic              cell_valid,
	input  logic              cell_ready,
	input  cell_in_t          cell_data,
	input  logic              tet_valid,
	input  logic              tet_ready,
	input  tet_out_t          tet_data,
	output int                mismatches,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	// corner numbers a..d of each tetrahedron, even parity first, slots 0 to 4
	localparam logic [0:1][0:NUM_TETS-1][0:3][VERT_W-1:0] TET_CORNERS = {
		3'd0, 3'd1, 3'd2, 3'd4,  3'd1, 3'd3, 3'd2, 3'd7,  3'd2, 3'd6, 3'd4, 3'd7,
		3'd4, 3'd5, 3'd7, 3'd1,  3'd2, 3'd4, 3'd1, 3'd7,
		3'd0, 3'd1, 3'd3, 3'd5,  3'd2, 3'd0, 3'd3, 3'd6,  3'd7, 3'd4, 3'd3, 3'd6,
		3'd4, 3'd5, 3'd6, 3'd0,  3'd0, 3'd3, 3'd6, 3'd5
	};

	logic [CFG_RAW_W-1:0] grid_nx, grid_ny, grid_nz;
	tet_out_t pending_tets[$];
	tet_out_t want;
	string bad;

	function automatic logic [CFG_RAW_W-1:0] clamp_points(input logic [APB_DW-1:0] wr);
		logic [CFG_RAW_W-1:0] v;
		v = wr[CFG_RAW_W-1:0];
		if (v < MIN_POINTS)
			v = CFG_RAW_W'(MIN_POINTS);
		else if (v > MAX_POINTS_PER_AXIS)
			v = CFG_RAW_W'(MAX_POINTS_PER_AXIS);
		return v;
	endfunction

	// queue the tetrahedra that one cell yields under the current grid size
	function automatic void split_cell(input cell_in_t c);
		int unsigned x, y, z, nx, ny, nz, row, slice, base, lin;
		int unsigned corner[8];
		logic [BORDER_W-1:0] border;
		logic par;
		tet_out_t t;
		x = c.cell_x;
		y = c.cell_y;
		z = c.cell_z;
		nx = grid_nx;
		ny = grid_ny;
		nz = grid_nz;
		t = '0;
		if (x >= nx - 1 || y >= ny - 1 || z >= nz - 1) begin
			t.error = 1'b1;
			t.last = 1'b1;
			pending_tets.push_back(t);
		end else begin
			row = nx;
			slice = nx * ny;
			base = z * slice + y * row + x;
			for (int k = 0; k < 8; k++)
				corner[k] = base + (k & 1) + ((k >> 1) & 1) * row + ((k >> 2) & 1) * slice;
			lin = z * (ny - 1) * (nx - 1) + y * (nx - 1) + x;
			border = '0;
			border[BRD_LEFT]   = (x == 0);
			border[BRD_RIGHT]  = (x + 1 == nx - 1);
			border[BRD_BOTTOM] = (y == 0);
			border[BRD_TOP]    = (y + 1 == ny - 1);
			border[BRD_BACK]   = (z == 0);
			border[BRD_FRONT]  = (z + 1 == nz - 1);
			par = (x + y + z) & 1;
			for (int s = 0; s < NUM_TETS; s++) begin
				t.cell_index  = IDX_W'(lin);
				t.tet_slot    = SLOT_W'(s);
				t.corner_a    = IDX_W'(corner[TET_CORNERS[par][s][0]]);
				t.corner_b    = IDX_W'(corner[TET_CORNERS[par][s][1]]);
				t.corner_c    = IDX_W'(corner[TET_CORNERS[par][s][2]]);
				t.corner_d    = IDX_W'(corner[TET_CORNERS[par][s][3]]);
				t.cell_border = border;
				t.flip        = par;
				t.error       = 1'b0;
				t.last        = (s == NUM_TETS - 1);
				pending_tets.push_back(t);
			end
		end
	endfunction

	function automatic string describe(input tet_out_t t);
		return $sformatf("cell %0d slot %0d corners %0d %0d %0d %0d border %b flip %b err %b last %b",
			t.cell_index, t.tet_slot, t.corner_a, t.corner_b, t.corner_c, t.corner_d,
			t.cell_border, t.flip, t.error, t.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_nx = CFG_RAW_W'(MIN_POINTS);
			grid_ny = CFG_RAW_W'(MIN_POINTS);
			grid_nz = CFG_RAW_W'(MIN_POINTS);
			pending_tets.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_POINTS_X: grid_nx = clamp_points(pwdata);
					REG_POINTS_Y: grid_ny = clamp_points(pwdata);
					REG_POINTS_Z: grid_nz = clamp_points(pwdata);
					default: ;
				endcase
			end
			if (cell_valid && cell_ready)
				split_cell(cell_data);
			if (tet_valid && tet_ready) begin
				if (pending_tets.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected tetrahedron: %s", describe(tet_data));
				end else begin
					want = pending_tets.pop_front();
					bad = "";
					if (tet_data.cell_index !== want.cell_index) bad = {bad, " cell_index"};
					if (tet_data.tet_slot !== want.tet_slot) bad = {bad, " tet_slot"};
					if (tet_data.corner_a !== want.corner_a) bad = {bad, " corner_a"};
					if (tet_data.corner_b !== want.corner_b) bad = {bad, " corner_b"};
					if (tet_data.corner_c !== want.corner_c) bad = {bad, " corner_c"};
					if (tet_data.corner_d !== want.corner_d) bad = {bad, " corner_d"};
					if (tet_data.cell_border !== want.cell_border) bad = {bad, " cell_border"};
					if (tet_data.flip !== want.flip) bad = {bad, " flip"};
					if (tet_data.error !== want.error) bad = {bad, " error"};
					if (tet_data.last !== want.last) bad = {bad, " last"};
					if (bad != "") begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("tetrahedron mismatch at %0t on%s", $realtime, bad);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(tet_data));
						end
					end
				end
			end
			outstanding = pending_tets.size();
		end
	end

endmodule

// ===== tb/grid_cell_tetrahedra_indexer_top_tb.sv =====
// Testbench top for the grid cell indexer: clock, reset, APB setup, cell traffic and verdict
module grid_cell_tetrahedra_indexer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gcti_pkg::*;

	localparam logic [APB_AW-1:0] ADDR_POINTS_X = {REG_POINTS_X, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_POINTS_Y = {REG_POINTS_Y, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_POINTS_Z = {REG_POINTS_Z, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_UNMAPPED = 4'hC;
	localparam int RAW_MAX         = (1 << CFG_RAW_W) - 1;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int RANDOM_PHASES   = 6;
	localparam int CELLS_PER_PHASE = 25;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int fail_count;
	int outstanding;

	gcti_stream_if #(.data_t(cell_in_t)) cell_ch ();
	gcti_stream_if #(.data_t(tet_out_t)) tet_ch ();

	grid_cell_tetrahedra_indexer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cell_in (cell_ch),
		.tet_out (tet_ch)
	);

	grid_cell_tetrahedra_indexer_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.cell_valid  (cell_ch.valid),
		.cell_ready  (cell_ch.ready),
		.cell_data   (cell_ch.data),
		.tet_valid   (tet_ch.valid),
		.tet_ready   (tet_ch.ready),
		.tet_data    (tet_ch.data),
		.mismatches  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result sink: random stalls, or a long hold-off when one is requested
	initial begin
		tet_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				tet_ch.ready <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else begin
				tet_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic write_axis(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic offer_cell(input logic [COORD_W-1:0] x, y, z);
		while ($urandom_range(99) < send_idle_pct) begin
			cell_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cell_ch.valid <= 1'b1;
		cell_ch.data <= '{cell_x: x, cell_y: y, cell_z: z};
		do @(posedge clk); while (!cell_ch.ready);
	endtask

	// drop valid, wait for every tetrahedron, then let the pipeline go quiet
	task automatic settle();
		cell_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int unsigned pick_points();
		case ($urandom_range(7))
			0: return MIN_POINTS;
			1: return MAX_POINTS_DEF;
			2: return $urandom_range(MAX_POINTS_DEF, MIN_POINTS);
			default: return $urandom_range(9, MIN_POINTS);
		endcase
	endfunction

	// bus word that stores as n: clamp-range aliases and junk above the field
	function automatic logic [APB_DW-1:0] encode_points(input int unsigned n);
		logic [CFG_RAW_W-1:0] raw;
		logic [APB_DW-CFG_RAW_W-1:0] junk;
		raw = CFG_RAW_W'(n);
		if (n == MIN_POINTS && $urandom_range(1))
			raw = CFG_RAW_W'($urandom_range(1));
		if (n == MAX_POINTS_DEF && $urandom_range(1))
			raw = CFG_RAW_W'($urandom_range(RAW_MAX, MAX_POINTS_DEF));
		junk = ($urandom_range(3) == 0) ? (APB_DW-CFG_RAW_W)'($urandom) : '0;
		return {junk, raw};
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(input int unsigned n);
		case ($urandom_range(29))
			0: return COORD_W'($urandom);
			1: return COORD_W'(n - 1);
			2: return '0;
			3: return COORD_W'(n - 2);
			default: return COORD_W'($urandom_range(n - 2));
		endcase
	endfunction

	task automatic run_random_phase(input bit full_grid, input bit squeeze);
		int unsigned nx, ny, nz;
		if (full_grid) begin
			nx = MAX_POINTS_DEF;
			ny = MAX_POINTS_DEF;
			nz = MAX_POINTS_DEF;
		end else begin
			nx = pick_points();
			ny = pick_points();
			nz = pick_points();
		end
		write_axis(ADDR_POINTS_X, encode_points(nx));
		write_axis(ADDR_POINTS_Y, encode_points(ny));
		write_axis(ADDR_POINTS_Z, encode_points(nz));
		if (squeeze)
			hold_cycles <= HOLD_OFF_CYCLES;
		repeat (CELLS_PER_PHASE)
			offer_cell(pick_coord(nx), pick_coord(ny), pick_coord(nz));
		settle();
	endtask

	initial begin
		cell_ch.valid <= 1'b0;
		cell_ch.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset grid is 2x2x2: one cell, everything else is out of range
		offer_cell(8'd0, 8'd0, 8'd0);
		offer_cell(8'd1, 8'd0, 8'd0);
		offer_cell(8'd0, 8'd1, 8'd0);
		offer_cell(8'd0, 8'd0, 8'd1);
		offer_cell(8'd255, 8'd255, 8'd255);
		settle();

		// largest grid, plus a write to an unmapped register that must change nothing
		write_axis(ADDR_POINTS_X, 32'd256);
		write_axis(ADDR_POINTS_Y, 32'd256);
		write_axis(ADDR_POINTS_Z, 32'd256);
		write_axis(ADDR_UNMAPPED, 32'd7);
		offer_cell(8'd0, 8'd0, 8'd0);
		offer_cell(8'd254, 8'd254, 8'd254);
		offer_cell(8'd255, 8'd0, 8'd0);
		offer_cell(8'd0, 8'd255, 8'd0);
		offer_cell(8'd0, 8'd0, 8'd255);
		offer_cell(8'd254, 8'd0, 8'd1);
		offer_cell(8'd1, 8'd254, 8'd0);
		offer_cell(8'd0, 8'd1, 8'd254);
		offer_cell(8'd128, 8'd127, 8'd1);
		offer_cell(8'd85, 8'd170, 8'd85);
		settle();

		// clamp low, clamp high, and bits above the field ignored
		write_axis(ADDR_POINTS_X, 32'd1);
		write_axis(ADDR_POINTS_Y, 32'd300);
		write_axis(ADDR_POINTS_Z, 32'hFFFF_FE03);
		offer_cell(8'd0, 8'd0, 8'd0);
		offer_cell(8'd0, 8'd254, 8'd1);
		offer_cell(8'd1, 8'd0, 8'd0);
		offer_cell(8'd0, 8'd0, 8'd2);
		offer_cell(8'd0, 8'd255, 8'd0);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			send_idle_pct = (p < 2) ? 10 : (p < 4) ? 80 : 0;
			recv_idle_pct = (p < 2) ? 80 : (p < 4) ? 10 : 0;
			run_random_phase(p == 2, p == 4);
		end

		if (fail_count == 0 && outstanding == 0)
			$display("grid_cell_tetrahedra_indexer_top verification clean");
		else
			$display("grid_cell_tetrahedra_indexer_top verification failed");
		$finish;
	end

	initial begin
		#500000;
		$display("grid_cell_tetrahedra_indexer_top verification failed");
		$finish;
	end

endmodule
